>>> sv/obps_pkg.sv
// types and codes shared by the order book priority store
`default_nettype none
package obps_pkg;

	localparam logic [1:0] FUNC_ADD    = 2'd0;
	localparam logic [1:0] FUNC_CANCEL = 2'd1;
	localparam logic [1:0] FUNC_QUERY  = 2'd2;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;

	localparam logic SIDE_BID = 1'b0;
	localparam logic SIDE_ASK = 1'b1;

	typedef struct packed {
		logic [1:0]  func;
		logic        side;
		logic [63:0] order_id;
		logic [31:0] price;
		logic [31:0] quantity;
		logic [31:0] sequence_req;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic       found;
	} rsp_t;

	typedef struct packed {
		logic [63:0] id;
		logic [31:0] price;
		logic [31:0] quantity;
		logic [31:0] seq;
	} entry_t;

	// per-side control broadcast to every cell; new_entry.id doubles as search key
	typedef struct packed {
		logic   add_en;
		logic   rm_en;
		entry_t new_entry;
	} side_ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_BUSY
	} fsm_t;

endpackage
`default_nettype wire

>>> sv/obps_cell.sv
// one slot of a sorted book: holds an entry and shifts toward either neighbor
`default_nettype none
module obps_cell import obps_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      ask_side,
	input  wire side_ctl_t ctl,
	input  wire entry_t    prev_entry,
	input  wire logic      prev_valid,
	input  wire logic      prev_cond,
	input  wire entry_t    next_entry,
	input  wire logic      next_valid,
	input  wire logic      hit_in,
	output entry_t         entry,
	output logic           valid,
	output logic           cond,
	output logic           hit_out
);

	entry_t entry_q;
	entry_t entry_d;
	logic   valid_q;
	logic   valid_d;
	logic   better;
	logic   earlier;
	logic   match;

	always_comb begin
		better  = ask_side ? (ctl.new_entry.price < entry_q.price)
		                   : (ctl.new_entry.price > entry_q.price);
		earlier = (ctl.new_entry.price == entry_q.price) &&
		          (ctl.new_entry.seq < entry_q.seq);
		// empty slots also count as "new goes here or earlier"
		cond    = !valid_q || better || earlier;
		match   = valid_q && (entry_q.id == ctl.new_entry.id);
		hit_out = hit_in || match;
	end

	always_comb begin
		entry_d = entry_q;
		valid_d = valid_q;
		if (ctl.rm_en && hit_out) begin
			// first match and everything behind it close up
			entry_d = next_entry;
			valid_d = next_valid;
		end else if (ctl.add_en) begin
			if (prev_cond) begin
				entry_d = prev_entry;
				valid_d = prev_valid;
			end else if (cond) begin
				entry_d = ctl.new_entry;
				valid_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;
	assign valid = valid_q;

endmodule
`default_nettype wire

>>> sv/obps_side.sv
// one side of the book: a row of cells kept in priority order
`default_nettype none
module obps_side import obps_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      ask_side,
	input  wire side_ctl_t ctl,
	output logic           hit,
	output logic           full
);

	entry_t cell_entry [DEPTH];
	logic   cell_valid [DEPTH];
	logic   cell_cond  [DEPTH];
	logic   cell_hit   [DEPTH];
	entry_t prev_entry [DEPTH];
	logic   prev_valid [DEPTH];
	logic   prev_cond  [DEPTH];
	entry_t next_entry [DEPTH];
	logic   next_valid [DEPTH];
	logic   hit_in     [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign prev_entry[i] = ctl.new_entry;
			assign prev_valid[i] = 1'b0;
			assign prev_cond[i]  = 1'b0;
			assign hit_in[i]     = 1'b0;
		end else begin : g_body
			assign prev_entry[i] = cell_entry[i-1];
			assign prev_valid[i] = cell_valid[i-1];
			assign prev_cond[i]  = cell_cond[i-1];
			assign hit_in[i]     = cell_hit[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign next_entry[i] = cell_entry[i];
			assign next_valid[i] = 1'b0;
		end else begin : g_mid
			assign next_entry[i] = cell_entry[i+1];
			assign next_valid[i] = cell_valid[i+1];
		end

		obps_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ask_side   (ask_side),
			.ctl        (ctl),
			.prev_entry (prev_entry[i]),
			.prev_valid (prev_valid[i]),
			.prev_cond  (prev_cond[i]),
			.next_entry (next_entry[i]),
			.next_valid (next_valid[i]),
			.hit_in     (hit_in[i]),
			.entry      (cell_entry[i]),
			.valid      (cell_valid[i]),
			.cond       (cell_cond[i]),
			.hit_out    (cell_hit[i])
		);
	end

	assign hit  = cell_hit[DEPTH-1];
	assign full = cell_valid[DEPTH-1];

endmodule
`default_nettype wire

>>> sv/order_book_priority_store_unit.sv
// top level of the order book priority store
//
// two sorted books of resting orders, bids by highest price and asks by
// lowest price, ties by lower sequence, equal keys behind existing entries
// req channel (req_valid/req_ready/req): one operation per transfer
//   add inserts into its side, cancel removes the first id match (bids
//   first), query reports whether the id rests in either side
// rsp channel (rsp_valid/rsp_ready/rsp): exactly one result per operation
// each side is a row of DEPTH cells; every cell compares the registered
// operation against its own entry and shifts toward a neighbor when the
// operation commits; a request is first taken into the operation register,
// then the cell row compares and shifts while the result is written to the
// output register, and no new request is taken until that commit
// a result waiting in the output register does not block the next request;
// if the receiver stalls, the following operation holds before it updates
// the books until the output register frees
// reset empties both books at once (cell valid flags clear), no sweep
`default_nettype none
module order_book_priority_store_unit import obps_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	fsm_t      state_q;
	fsm_t      state_d;
	req_t      op_q;
	rsp_t      rsp_q;
	rsp_t      rsp_d;
	logic      rsp_valid_q;
	logic      commit;
	logic      bid_hit;
	logic      ask_hit;
	logic      bid_full;
	logic      ask_full;
	logic      side_full;
	entry_t    new_entry;
	side_ctl_t bid_ctl;
	side_ctl_t ask_ctl;

	// fsm: idle takes a request, busy commits it once the output register is free
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		commit    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = ST_BUSY;
				end
			end
			ST_BUSY: begin
				if (!rsp_valid_q || rsp_ready) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// operation register, loaded on each request transfer
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			op_q <= req;
		end
	end

	// broadcast to both cell rows
	always_comb begin
		new_entry.id       = op_q.order_id;
		new_entry.price    = op_q.price;
		new_entry.quantity = op_q.quantity;
		new_entry.seq      = op_q.sequence_req;
		side_full          = (op_q.side == SIDE_ASK) ? ask_full : bid_full;

		bid_ctl.new_entry = new_entry;
		bid_ctl.add_en    = commit && (op_q.func == FUNC_ADD) &&
		                    (op_q.side == SIDE_BID) && !bid_full;
		bid_ctl.rm_en     = commit && (op_q.func == FUNC_CANCEL);

		ask_ctl.new_entry = new_entry;
		ask_ctl.add_en    = commit && (op_q.func == FUNC_ADD) &&
		                    (op_q.side == SIDE_ASK) && !ask_full;
		// ask entries are only removed when no bid carries the id
		ask_ctl.rm_en     = commit && (op_q.func == FUNC_CANCEL) && !bid_hit;
	end

	obps_side #(
		.DEPTH (DEPTH)
	) u_bid (
		.clk      (clk),
		.arst_n   (arst_n),
		.ask_side (SIDE_BID),
		.ctl      (bid_ctl),
		.hit      (bid_hit),
		.full     (bid_full)
	);

	obps_side #(
		.DEPTH (DEPTH)
	) u_ask (
		.clk      (clk),
		.arst_n   (arst_n),
		.ask_side (SIDE_ASK),
		.ctl      (ask_ctl),
		.hit      (ask_hit),
		.full     (ask_full)
	);

	// result of the operation being committed
	always_comb begin
		rsp_d.status = STATUS_OK;
		rsp_d.found  = 1'b0;
		case (op_q.func)
			FUNC_ADD: begin
				if (side_full) begin
					rsp_d.status = STATUS_FULL;
				end
			end
			FUNC_CANCEL: begin
				if (!bid_hit && !ask_hit) begin
					rsp_d.status = STATUS_NOT_FOUND;
				end
			end
			FUNC_QUERY: begin
				rsp_d.found = bid_hit || ask_hit;
			end
			default: begin
				rsp_d.status = STATUS_OK;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

>>> sv/obps_checker.sv
// port-level checks for the order book priority store, bound to the top level
`default_nettype none
module obps_checker import obps_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire req_t req,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp
);

	// one operation in flight: no second request right after a transfer
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while an operation is in flight");

	// a fresh result only follows a cycle spent working on an operation
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("result appeared without an operation in flight");

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled result changed");

	// a found id is only reported with an ok status
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.found) |-> (rsp.status == STATUS_OK))
		else $error("found flag with an error status");

endmodule

bind order_book_priority_store_unit obps_checker u_obps_checker (.*);
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps
// order book priority store testbench: directed and random flow checked against behavioral books
module testbench;
	import obps_pkg::*;

	localparam int BOOK_DEPTH   = 64;
	localparam int RANDOM_ITEMS = 1000;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_AFTER   = 300;    // results seen before the long receiver hold-off
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 10;
	localparam int ID_POOL      = 48;

	// func code 3 is unused by the block and must come back as a plain ok
	localparam logic [1:0] FUNC_NOOP = 2'd3;

	typedef struct {
		req_t r;
		bit   settle;    // sender waits for every result before offering this one
	} flow_item_t;

	typedef struct {
		logic [63:0] id;
		logic        s;
	} resting_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// behavioral copy of both books, indexed by side code
	entry_t book [2][BOOK_DEPTH];
	int     book_n [2] = '{0, 0};

	flow_item_t  order_flow [$];     // items waiting to be offered
	rsp_t        awaited_rsp [$];    // predicted results in transfer order
	resting_t    resting [$];        // generator's rough view of the resting ids
	int          planned_n [2] = '{0, 0};
	logic [63:0] id_pool [ID_POOL];

	int taken_cnt = 0;
	int issued_cnt = 0;
	int results_seen = 0;
	int faults = 0;
	int made = 0;
	int cycle_cnt = 0;

	int send_gap = 0;
	int send_calm = 0;
	int take_gap = 0;
	int take_calm = 0;
	int take_seen = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	order_book_priority_store_unit #(
		.DEPTH(BOOK_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	// price-time priority: better price first, then lower sequence; equal keys queue behind
	function automatic bit goes_first(entry_t a, entry_t b, logic s);
		bit better;
		better = (s == SIDE_BID) ? (a.price > b.price) : (a.price < b.price);
		return better || (a.price == b.price && a.seq < b.seq);
	endfunction

	function automatic int locate_id(int s, logic [63:0] id);
		int i;
		for (i = 0; i < book_n[s]; i++)
			if (book[s][i].id == id)
				return i;
		return -1;
	endfunction

	// applies one operation to the behavioral books and returns its result
	function automatic rsp_t book_apply(req_t r);
		rsp_t   res;
		entry_t e;
		int     s;
		int     pos;
		int     k;
		res = '0;
		case (r.func)
			FUNC_ADD: begin
				s = int'(r.side);
				e.id = r.order_id;
				e.price = r.price;
				e.quantity = r.quantity;
				e.seq = r.sequence_req;
				if (book_n[s] >= BOOK_DEPTH) begin
					res.status = STATUS_FULL;
				end else begin
					pos = 0;
					while (pos < book_n[s] && !goes_first(e, book[s][pos], r.side))
						pos++;
					for (k = book_n[s]; k > pos; k--)
						book[s][k] = book[s][k - 1];
					book[s][pos] = e;
					book_n[s]++;
				end
			end
			FUNC_CANCEL: begin
				// bids are searched before asks
				s = int'(SIDE_BID);
				pos = locate_id(s, r.order_id);
				if (pos < 0) begin
					s = int'(SIDE_ASK);
					pos = locate_id(s, r.order_id);
				end
				if (pos < 0) begin
					res.status = STATUS_NOT_FOUND;
				end else begin
					for (k = pos; k + 1 < book_n[s]; k++)
						book[s][k] = book[s][k + 1];
					book_n[s]--;
				end
			end
			FUNC_QUERY: begin
				res.found = (locate_id(int'(SIDE_BID), r.order_id) >= 0) ||
					(locate_id(int'(SIDE_ASK), r.order_id) >= 0);
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	function automatic req_t make_order(logic [1:0] f, logic s, logic [63:0] id,
		logic [31:0] p, logic [31:0] q, logic [31:0] arrival);
		req_t r;
		r.func = f;
		r.side = s;
		r.order_id = id;
		r.price = p;
		r.quantity = q;
		r.sequence_req = arrival;
		return r;
	endfunction

	// random content; narrow price and sequence ranges make ties common
	function automatic req_t random_order(logic [1:0] f, logic s);
		logic [63:0] id;
		logic [31:0] p;
		logic [31:0] arrival;
		if ($urandom_range(0, 9) < 7)
			id = id_pool[$urandom_range(0, ID_POOL - 1)];
		else
			id = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: p = $urandom;
			1: p = 32'd1000 + $urandom_range(0, 4);
			2: p = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
			default: p = 32'h8000_0000 + $urandom_range(0, 7);
		endcase
		arrival = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 3));
		return make_order(f, s, id, p, $urandom, arrival);
	endfunction

	// queues an item and keeps the generator's view of the books roughly in step
	task automatic queue_order(req_t r, bit settle);
		flow_item_t it;
		int         i;
		it.r = r;
		it.settle = settle;
		order_flow.push_back(it);
		if (r.func != FUNC_NOOP)
			made++;
		if (r.func == FUNC_ADD && planned_n[r.side] < BOOK_DEPTH) begin
			planned_n[r.side]++;
			resting.push_back('{r.order_id, r.side});
		end
		if (r.func == FUNC_CANCEL) begin
			for (i = 0; i < resting.size(); i++) begin
				if (resting[i].id == r.order_id) begin
					planned_n[resting[i].s]--;
					resting.delete(i);
					break;
				end
			end
		end
	endtask

	// a live id most of the time, otherwise anything from the pool or fresh
	function automatic logic [63:0] pick_id(int live_pct);
		req_t tmp;
		if (resting.size() != 0 && $urandom_range(0, 99) < live_pct)
			return resting[$urandom_range(0, resting.size() - 1)].id;
		tmp = random_order(FUNC_QUERY, SIDE_BID);
		return tmp.order_id;
	endfunction

	// idle draw per item, with occasional stretches of back-to-back traffic
	function automatic int draw_idle(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		return $urandom_range(0, 15);
	endfunction

	task automatic log_fault(string msg);
		faults++;
		if (faults <= 10)
			$display("%s", msg);
	endtask

	// request transfers feed the prediction, response transfers are checked in order
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				awaited_rsp.push_back(book_apply(req));
				taken_cnt <= taken_cnt + 1;
			end
			if (rsp_valid && rsp_ready) begin
				results_seen <= results_seen + 1;
				if (awaited_rsp.size() == 0) begin
					log_fault($sformatf("unexpected result %0d: status %0d found %0b",
						results_seen, rsp.status, rsp.found));
				end else begin
					want = awaited_rsp.pop_front();
					if (rsp.status !== want.status)
						log_fault($sformatf("result %0d status: expected %0d, got %0d",
							results_seen, want.status, rsp.status));
					if (rsp.found !== want.found)
						log_fault($sformatf("result %0d found: expected %0b, got %0b",
							results_seen, want.found, rsp.found));
				end
			end
		end
	end

	// sender: offers the next item once the previous transfer has happened
	always @(negedge clk) begin
		flow_item_t nxt;
		if (arst_n && taken_cnt == issued_cnt) begin
			if (send_gap > 0) begin
				send_gap--;
				req_valid <= 1'b0;
			end else if (order_flow.size() != 0 &&
				!(order_flow[0].settle && awaited_rsp.size() != 0)) begin
				nxt = order_flow.pop_front();
				req <= nxt.r;
				req_valid <= 1'b1;
				issued_cnt <= issued_cnt + 1;
				send_gap = draw_idle(send_calm);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted here so the input side backs up
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_seen >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// receiver: stalls a drawn number of cycles after each transfer
	always @(negedge clk) begin
		if (arst_n) begin
			if (results_seen != take_seen) begin
				take_seen = results_seen;
				take_gap = draw_idle(take_calm);
			end
			if (hold_left > 0) begin
				rsp_ready <= 1'b0;
			end else if (take_gap > 0) begin
				take_gap--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		logic [63:0] id_a;
		logic [63:0] id_b;
		logic [63:0] id_c;
		logic [63:0] id_d;
		logic [63:0] absent_id;
		logic [63:0] ones;
		int          i;
		int          n;
		int          roll;
		int          target;
		logic        s;

		ones = '1;
		id_pool[0] = '0;
		id_pool[1] = ones;
		for (i = 2; i < ID_POOL; i++)
			id_pool[i] = {$urandom, $urandom};
		id_a = id_pool[2];
		id_b = id_pool[3];
		id_c = id_pool[4];
		id_d = id_pool[5];
		absent_id = 64'h0123_4567_89AB_CDEF;

		// directed: field extremes, priority ties, duplicate ids, every func code
		queue_order(make_order(FUNC_ADD, SIDE_BID, '0, '0, '0, '0), 1'b0);
		queue_order(make_order(FUNC_ADD, SIDE_BID, ones, '1, '1, '1), 1'b0);
		queue_order(make_order(FUNC_ADD, SIDE_BID, id_a, 32'd100, 32'd10, 32'd5), 1'b0);
		// equal price and sequence goes behind the resting one
		queue_order(make_order(FUNC_ADD, SIDE_BID, id_b, 32'd100, 32'd20, 32'd5), 1'b0);
		queue_order(make_order(FUNC_ADD, SIDE_BID, id_c, 32'd100, 32'd30, 32'd2), 1'b0);
		queue_order(make_order(FUNC_ADD, SIDE_ASK, id_d, '1, 32'd1, '0), 1'b0);
		queue_order(make_order(FUNC_ADD, SIDE_ASK, id_c, '0, 32'd2, '1), 1'b0);
		// same id resting on both sides
		queue_order(make_order(FUNC_ADD, SIDE_ASK, id_a, 32'd200, 32'd3, 32'd7), 1'b0);
		queue_order(make_order(FUNC_ADD, SIDE_ASK, id_b, 32'd200, 32'd4, 32'd1), 1'b0);
		queue_order(make_order(FUNC_QUERY, SIDE_BID, id_a, '1, '1, '1), 1'b0);
		queue_order(make_order(FUNC_QUERY, SIDE_ASK, absent_id, '0, '0, '0), 1'b0);
		// cancel takes the bid copy first, then the ask copy, then misses
		queue_order(make_order(FUNC_CANCEL, SIDE_ASK, id_a, '0, '0, '0), 1'b0);
		queue_order(make_order(FUNC_QUERY, SIDE_BID, id_a, '0, '0, '0), 1'b0);
		queue_order(make_order(FUNC_CANCEL, SIDE_BID, id_a, '1, '1, '1), 1'b0);
		queue_order(make_order(FUNC_QUERY, SIDE_BID, id_a, '0, '0, '0), 1'b0);
		queue_order(make_order(FUNC_CANCEL, SIDE_BID, id_a, '0, '0, '0), 1'b0);
		queue_order(make_order(FUNC_CANCEL, SIDE_ASK, ones, '0, '0, '0), 1'b0);
		queue_order(make_order(FUNC_NOOP, SIDE_ASK, id_b, '1, '1, '1), 1'b0);
		queue_order(make_order(FUNC_QUERY, SIDE_BID, '0, '0, '0, '0), 1'b0);
		queue_order(make_order(FUNC_CANCEL, SIDE_BID, id_c, '0, '0, '0), 1'b0);
		queue_order(make_order(FUNC_QUERY, SIDE_ASK, id_c, '0, '0, '0), 1'b0);
		queue_order(make_order(FUNC_ADD, SIDE_BID, id_b, 32'd100, 32'd5, 32'd5), 1'b0);
		queue_order(make_order(FUNC_CANCEL, SIDE_BID, id_b, '0, '0, '0), 1'b0);
		queue_order(make_order(FUNC_QUERY, SIDE_BID, id_b, '0, '0, '0), 1'b0);

		// random phases: the first two fill each side to refusal, the sender
		// settles before the first one and at some later phase starts
		target = made + RANDOM_ITEMS;
		n = 0;
		while (made < target) begin
			roll = (n < 2) ? 0 : $urandom_range(0, 11);
			s = (n < 2) ? n[0] : 1'($urandom_range(0, 1));
			if (roll == 0) begin
				// fill one side, then push a few adds that must be refused
				queue_order(random_order(FUNC_ADD, s), n == 0 || $urandom_range(0, 3) == 0);
				while (planned_n[s] < BOOK_DEPTH) begin
					if ($urandom_range(0, 7) == 0)
						queue_order(make_order(FUNC_QUERY, s, pick_id(60), $urandom,
							$urandom, $urandom), 1'b0);
					queue_order(random_order(FUNC_ADD, s), 1'b0);
				end
				for (i = $urandom_range(2, 5); i > 0; i--)
					queue_order(random_order(FUNC_ADD, s), 1'b0);
			end else if (roll <= 3) begin
				// drain: mostly cancels of resting ids, some misses
				for (i = $urandom_range(10, 70); i > 0; i--)
					queue_order(make_order(FUNC_CANCEL, 1'($urandom_range(0, 1)),
						pick_id(85), $urandom, $urandom, $urandom),
						i == 1 && $urandom_range(0, 3) == 0);
			end else begin
				// mixed order flow
				for (i = $urandom_range(20, 80); i > 0; i--) begin
					roll = $urandom_range(0, 19);
					if (roll == 0)
						queue_order(random_order(FUNC_NOOP, 1'($urandom_range(0, 1))), 1'b0);
					else if (roll <= 8)
						queue_order(random_order(FUNC_ADD, 1'($urandom_range(0, 1))), 1'b0);
					else if (roll <= 13)
						queue_order(make_order(FUNC_CANCEL, 1'($urandom_range(0, 1)),
							pick_id(70), $urandom, $urandom, $urandom), 1'b0);
					else
						queue_order(make_order(FUNC_QUERY, 1'($urandom_range(0, 1)),
							pick_id(60), $urandom, $urandom, $urandom), 1'b0);
				end
			end
			n++;
		end

		// single reset at the start, released on a falling edge
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (order_flow.size() != 0 || taken_cnt != issued_cnt)
			@(posedge clk);
		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (awaited_rsp.size() != 0)
			log_fault($sformatf("%0d results never arrived", awaited_rsp.size()));
		if (faults == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
